FILE: hdl/fac_pkg.sv
`timescale 1ns / 1ps
package fac_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int CH_W         = 1;
  localparam int SAMPLE_W     = 24;
  localparam int GAIN_W       = 17;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAKEUP    = 3'd4;

  localparam logic [16:0] UNITY_Q16 = 17'd65536;
  localparam logic [9:0]  SLEW_Q16  = 10'd655;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENV,
    ST_DECIDE,
    ST_LOG_SET,
    ST_LOG_ITER,
    ST_EXPO,
    ST_EXP_ITER,
    ST_TGT,
    ST_GAIN,
    ST_GMUL,
    ST_OUT
  } fac_state_t;

  typedef logic [15:0][30:0] fact_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_m;
    v = v_in;
    res = 64'd0;
    bit_m = 64'd1 << 62;
    while (bit_m > v) bit_m = bit_m >> 2;
    while (bit_m != 64'd0) begin
      if (v >= res + bit_m) begin
        v = v - (res + bit_m);
        res = (res >> 1) + bit_m;
      end else begin
        res = res >> 1;
      end
      bit_m = bit_m >> 2;
    end
    return res;
  endfunction

  // factor for fraction bit k is 2^(-2^(k-16)) in Q1.30
  function automatic fact_tab_t make_fact_tab();
    fact_tab_t t;
    logic [63:0] c;
    c = isqrt64(64'd1 << 59);
    for (int k = 15; k >= 0; k--) begin
      t[k] = c[30:0];
      c = isqrt64(c << 30);
    end
    return t;
  endfunction

  localparam fact_tab_t EXP_FACT = make_fact_tab();

  function automatic logic [4:0] msb24(input logic [23:0] x);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (x[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

FILE: hdl/fac_in_if.sv
`timescale 1ns / 1ps
interface fac_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [fac_pkg::CH_W-1:0]               channel;
  logic signed [fac_pkg::SAMPLE_W-1:0]    sample_in;

  modport source(output valid, channel, sample_in, input ready);
  modport sink(input valid, channel, sample_in, output ready);
endinterface

FILE: hdl/fac_out_if.sv
`timescale 1ns / 1ps
interface fac_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [fac_pkg::SAMPLE_W-1:0]    sample_out;

  modport source(output valid, sample_out, input ready);
  modport sink(input valid, sample_out, output ready);
endinterface

FILE: hdl/feed_forward_audio_compressor.sv
`timescale 1ns / 1ps
// When the envelope stays at or below threshold (or ratio or threshold is zero),
// log2 and exp2 are skipped; exp2 is skipped when the gain shift saturates, and an
// out-of-range channel goes straight to a zero result. Each result waits for
// out_ch.ready. in_ch.ready is high only while idle, so no new item is taken until
// the last is done; one shared 34x32 multiplier runs 16 steps per log2, 16 for exp2.
// Reset (rst_n low, synchronous): config registers take defaults, envelopes clear,
// smoothed gains go to unity, no result pending.
module feed_forward_audio_compressor (
  input  logic                               clk,
  input  logic                               rst_n,
  fac_in_if.sink                             in_ch,
  fac_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [fac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fac_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fac_pkg::*;

  // configuration
  logic [16:0] thr_r;
  logic [23:0] attack_r;
  logic [23:0] release_r;
  logic [15:0] ratio_r;
  logic [15:0] makeup_r;

  // per-channel state
  logic [23:0]       env_arr_r  [NUM_CHANNELS];
  logic [GAIN_W-1:0] gain_arr_r [NUM_CHANNELS];

  // sequencer
  fac_state_t state_r, state_nxt;

  // item registers
  logic [CH_W-1:0] ch_r;
  logic            bad_r;
  logic            neg_r;
  logic [23:0]     mag_r;
  logic [23:0]     env_r;
  logic [30:0]     m_r;
  logic [20:0]     r_r;
  logic [20:0]     log_env_r;
  logic [3:0]      i_r;
  logic            second_r;
  logic [20:0]     e_r;
  logic [30:0]     acc_r;
  logic [3:0]      k_r;
  logic [16:0]     tgt_r;
  logic [32:0]     gm_r;

  logic                        out_valid_r;
  logic signed [SAMPLE_W-1:0]  out_data_r;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] prod;

  logic        accept;
  logic        out_free;
  logic [23:0] lvl;
  logic [23:0] env_cur;
  logic [16:0] gain_cur;
  logic [23:0] in_mag;
  logic [23:0] log_x;
  logic [4:0]  log_p;
  logic [31:0] sq;
  logic [20:0] d_log;
  logic [20:0] e_new;
  logic [4:0]  n_sh;
  logic [4:0]  tgt_sh;
  logic [31:0] tgt_sum;
  logic [65:0] env_sum;
  logic [65:0] gain_sum;
  logic [65:0] acc_sum;
  logic [65:0] out_sum;
  logic [29:0] q_mag;
  logic        uncompressed;

  assign lvl      = {thr_r, 7'd0};
  assign env_cur  = env_arr_r[ch_r];
  assign gain_cur = gain_arr_r[ch_r];
  assign in_mag   = in_ch.sample_in[SAMPLE_W-1] ? 24'(-in_ch.sample_in)
                                                : 24'(in_ch.sample_in);
  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign prod = mul_a * mul_b;

  assign log_x    = second_r ? lvl : env_r;
  assign log_p    = msb24(log_x);
  assign sq       = prod[61:30];
  assign d_log    = log_env_r - r_r;
  assign e_new    = prod[36:16];
  assign n_sh     = e_r[20:16];
  assign tgt_sh   = 5'd14 + n_sh;
  assign tgt_sum  = {1'b0, acc_r} + (32'd1 << (tgt_sh - 5'd1));
  // env' = mag + coef*(env - mag), rounded at Q24
  assign env_sum  = ({42'd0, mag_r} << 24) + 66'(prod) + 66'd8388608;
  assign gain_sum = ({49'd0, gain_cur} << 16) + 66'(prod) + 66'd32768;
  assign acc_sum  = 66'(prod) + (66'd1 << 29);
  assign out_sum  = 66'(prod) + (66'd1 << 27);
  assign q_mag    = out_sum[57:28];
  assign uncompressed = (ratio_r == 16'd0) || (env_r <= lvl);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (32'(in_ch.channel) >= NUM_CHANNELS) ? ST_OUT : ST_ENV;
        end
      end
      ST_ENV:     state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (uncompressed || lvl == 24'd0) state_nxt = ST_GAIN;
        else                              state_nxt = ST_LOG_SET;
      end
      ST_LOG_SET: state_nxt = ST_LOG_ITER;
      ST_LOG_ITER: begin
        if (i_r == 4'd0) state_nxt = second_r ? ST_EXPO : ST_LOG_SET;
      end
      ST_EXPO: begin
        state_nxt = (e_new[20:16] >= 5'd17) ? ST_GAIN : ST_EXP_ITER;
      end
      ST_EXP_ITER: begin
        if (k_r == 4'd0) state_nxt = ST_TGT;
      end
      ST_TGT:  state_nxt = ST_GAIN;
      ST_GAIN: state_nxt = ST_GMUL;
      ST_GMUL: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: ready and multiplier operands
  always_comb begin
    in_ch.ready = 1'b0;
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_ENV: begin
        mul_a = 34'($signed({1'b0, env_cur}) - $signed({1'b0, mag_r}));
        mul_b = $signed({8'd0, (mag_r > env_cur) ? attack_r : release_r});
      end
      ST_LOG_ITER: begin
        mul_a = $signed({3'd0, m_r});
        mul_b = $signed({1'b0, m_r});
      end
      ST_EXPO: begin
        mul_a = $signed({13'd0, d_log});
        mul_b = $signed({16'd0, ratio_r});
      end
      ST_EXP_ITER: begin
        mul_a = $signed({3'd0, acc_r});
        mul_b = $signed({1'b0, EXP_FACT[k_r]});
      end
      ST_GAIN: begin
        mul_a = 34'($signed({1'b0, tgt_r}) - $signed({1'b0, gain_cur}));
        mul_b = $signed({22'd0, SLEW_Q16});
      end
      ST_GMUL: begin
        mul_a = $signed({17'd0, gain_cur});
        mul_b = $signed({16'd0, makeup_r});
      end
      ST_OUT: begin
        mul_a = $signed({1'b0, gm_r});
        mul_b = $signed({8'd0, mag_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      thr_r       <= UNITY_Q16;
      attack_r    <= 24'd0;
      release_r   <= 24'd0;
      ratio_r     <= 16'd0;
      makeup_r    <= 16'd4096;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        env_arr_r[c]  <= 24'd0;
        gain_arr_r[c] <= UNITY_Q16;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: thr_r     <= cfg_data[16:0];
          REG_ATTACK:    attack_r  <= cfg_data;
          REG_RELEASE:   release_r <= cfg_data;
          REG_RATIO:     ratio_r   <= cfg_data[15:0];
          REG_MAKEUP:    makeup_r  <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (state_r == ST_ENV) env_arr_r[ch_r] <= env_sum[47:24];
      if (state_r == ST_GAIN) gain_arr_r[ch_r] <= gain_sum[32:16];
      if (state_r == ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)             out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ch_r     <= in_ch.channel;
        bad_r    <= 32'(in_ch.channel) >= NUM_CHANNELS;
        neg_r    <= in_ch.sample_in[SAMPLE_W-1];
        mag_r    <= in_mag;
        second_r <= 1'b0;
      end
      ST_ENV: env_r <= env_sum[47:24];
      ST_DECIDE: begin
        // target is unity at or below threshold or for a zero ratio, zero for a zero threshold
        if (uncompressed)       tgt_r <= UNITY_Q16;
        else if (lvl == 24'd0) tgt_r <= 17'd0;
      end
      ST_LOG_SET: begin
        m_r <= 31'({7'd0, log_x} << (5'd30 - log_p));
        r_r <= {log_p, 16'd0};
        i_r <= 4'd15;
      end
      ST_LOG_ITER: begin
        // square the mantissa; overflow past 2 yields the next fraction bit
        if (sq[31]) begin
          m_r <= sq[31:1];
          r_r <= r_r | (21'd1 << i_r);
        end else begin
          m_r <= sq[30:0];
        end
        i_r <= i_r - 4'd1;
        if (i_r == 4'd0 && !second_r) begin
          log_env_r <= sq[31] ? (r_r | 21'd1) : r_r;
          second_r  <= 1'b1;
        end
      end
      ST_EXPO: begin
        e_r   <= e_new;
        acc_r <= 31'd1 << 30;
        k_r   <= 4'd15;
        if (e_new[20:16] >= 5'd17) tgt_r <= 17'd0;
      end
      ST_EXP_ITER: begin
        if (e_r[k_r]) acc_r <= acc_sum[60:30];
        k_r <= k_r - 4'd1;
      end
      ST_TGT:  tgt_r <= 17'(tgt_sum >> tgt_sh);
      ST_GMUL: gm_r <= prod[32:0];
      ST_OUT: begin
        if (out_free) begin
          if (bad_r) begin
            out_data_r <= '0;
          end else if (neg_r) begin
            out_data_r <= (q_mag > 30'd8388608) ? 24'sh800000 : 24'(-q_mag);
          end else begin
            out_data_r <= (q_mag > 30'd8388607) ? 24'sh7FFFFF : 24'(q_mag);
          end
        end
      end
      default: ;
    endcase
  end

endmodule
